### sv/dust_extractor_valve_controller_top_macros.svh
// ---------------------------------------------------------------------------
// dust extractor valve controller assertion macros
// concurrent assertion shorthands for the checker file
// ---------------------------------------------------------------------------
`ifndef DUST_EXTRACTOR_VALVE_CONTROLLER_TOP_MACROS_SVH
`define DUST_EXTRACTOR_VALVE_CONTROLLER_TOP_MACROS_SVH

// property must hold at every edge outside reset
`define DEVC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DEVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/devc_pkg.sv
// ---------------------------------------------------------------------------
// devc_pkg
// types and codes of the dust extractor valve controller
// ---------------------------------------------------------------------------
package devc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN_TICKS    = 2'd2;

	localparam logic [9:0]  OFF_THRESHOLD_RST = 10'd52;
	localparam logic [7:0]  SETTLE_TICKS_RST  = 8'd25;
	localparam logic [15:0] SPIN_TICKS_RST    = 16'd100;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_TOGGLE = 2'd2;

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_MAN_A  = 3'd1,
		MODE_MAN_B  = 3'd2,
		MODE_AUTO_A = 3'd3,
		MODE_AUTO_B = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_SETTLE = 3'b010,
		PH_SPIN   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [9:0]  off_threshold;
		logic [7:0]  settle_ticks;
		logic [15:0] spin_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] requested_mode;
		logic [9:0] amps_a;
		logic [9:0] amps_b;
		logic       valve_a_pin;
		logic       valve_b_pin;
	} item_t;

	typedef struct packed {
		logic       vac_motor_on;
		logic       valve_motor_on;
		logic [2:0] mode_now;
		logic       busy_res;
		logic       ignored;
	} result_t;

endpackage

### sv/devc_ifs.sv
// ---------------------------------------------------------------------------
// devc channel interfaces
// command channel into the controller and status channel out of it
// ---------------------------------------------------------------------------
interface devc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [2:0] requested_mode;
	logic [9:0] amps_a;
	logic [9:0] amps_b;
	logic       valve_a_pin;
	logic       valve_b_pin;

	modport source (output valid, cmd, requested_mode, amps_a, amps_b,
		valve_a_pin, valve_b_pin, input ready);
	modport sink (input valid, cmd, requested_mode, amps_a, amps_b,
		valve_a_pin, valve_b_pin, output ready);
endinterface

interface devc_status_if;
	logic       valid;
	logic       ready;
	logic       vac_motor_on;
	logic       valve_motor_on;
	logic [2:0] mode_now;
	logic       busy_res;
	logic       ignored;

	modport source (output valid, vac_motor_on, valve_motor_on, mode_now, busy_res,
		ignored, input ready);
	modport sink (input valid, vac_motor_on, valve_motor_on, mode_now, busy_res,
		ignored, output ready);
endinterface

### sv/devc_cfg_regs.sv
// ---------------------------------------------------------------------------
// devc_cfg_regs
// threshold and timing registers behind the plain write port
// ---------------------------------------------------------------------------
module devc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [devc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [devc_pkg::CFG_DATA_W-1:0] cfg_data,
	output devc_pkg::cfg_t                 cfg
);
	import devc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_threshold <= OFF_THRESHOLD_RST;
			cfg_q.settle_ticks  <= SETTLE_TICKS_RST;
			cfg_q.spin_ticks    <= SPIN_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFF_THRESHOLD: cfg_q.off_threshold <= cfg_data[9:0];
				REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_data[7:0];
				REG_SPIN_TICKS:    cfg_q.spin_ticks    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/devc_core.sv
// ---------------------------------------------------------------------------
// devc_core
// mode and valve switching state with the per-item update logic
// ---------------------------------------------------------------------------
module devc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  devc_pkg::item_t   item,
	input  devc_pkg::cfg_t    cfg,
	output devc_pkg::result_t res
);
	import devc_pkg::*;

	mode_t       mode_q, mode_d;
	mode_t       target_q, target_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  settle_q, settle_d;
	logic [15:0] spin_q, spin_d;
	logic        vac_q, vac_d;
	logic        valve_q, valve_d;

	logic        busy;
	logic        ign;
	logic        do_enter;
	mode_t       enter_m;
	logic        want_a;
	logic        tgt_a;
	logic        tgt_pin;
	logic [7:0]  settle_load;
	logic [7:0]  settle_dec;
	logic [15:0] spin_dec;
	logic [10:0] on_level;

	assign busy        = (phase_q != PH_IDLE);
	assign settle_load = (cfg.settle_ticks == '0) ? 8'd1 : cfg.settle_ticks;
	assign settle_dec  = settle_q - 8'd1;
	assign spin_dec    = spin_q - 16'd1;
	assign on_level    = {cfg.off_threshold, 1'b0};
	assign tgt_a       = (target_q == MODE_MAN_A) || (target_q == MODE_AUTO_A);
	assign tgt_pin     = tgt_a ? item.valve_a_pin : item.valve_b_pin;
	assign want_a      = (enter_m == MODE_MAN_A) || (enter_m == MODE_AUTO_A);

	always_comb begin
		mode_d   = mode_q;
		target_d = target_q;
		phase_d  = phase_q;
		settle_d = settle_q;
		spin_d   = spin_q;
		vac_d    = vac_q;
		valve_d  = valve_q;
		ign      = 1'b0;
		do_enter = 1'b0;
		enter_m  = MODE_OFF;

		unique case (item.cmd)
			CMD_TICK: begin
				if (busy) begin
					if (phase_q == PH_SETTLE) begin
						if (tgt_pin) begin
							settle_d = settle_load;
						end else begin
							settle_d = settle_dec;
							if (settle_dec == '0) begin
								if (cfg.spin_ticks == '0) begin
									valve_d = 1'b0;
									vac_d   = 1'b1;
									mode_d  = target_q;
									phase_d = PH_IDLE;
								end else begin
									spin_d  = cfg.spin_ticks;
									phase_d = PH_SPIN;
								end
							end
						end
					end else begin
						spin_d = spin_dec;
						if (spin_dec == '0) begin
							valve_d = 1'b0;
							vac_d   = 1'b1;
							mode_d  = target_q;
							phase_d = PH_IDLE;
						end
					end
				end else begin
					// auto control: start on A before B, stop on the active outlet
					unique case (mode_q)
						MODE_OFF: begin
							if ({1'b0, item.amps_a} > on_level) begin
								do_enter = 1'b1;
								enter_m  = MODE_AUTO_A;
							end else if ({1'b0, item.amps_b} > on_level) begin
								do_enter = 1'b1;
								enter_m  = MODE_AUTO_B;
							end
						end
						MODE_AUTO_A: do_enter = (item.amps_a < cfg.off_threshold);
						MODE_AUTO_B: do_enter = (item.amps_b < cfg.off_threshold);
						default: ;
					endcase
				end
			end
			CMD_SET, CMD_TOGGLE: begin
				if (busy) begin
					ign = 1'b1;
				end else if (item.requested_mode <= MODE_AUTO_B) begin
					do_enter = 1'b1;
					// toggling the active mode selects off
					if (item.cmd == CMD_SET || mode_q != mode_t'(item.requested_mode))
						enter_m = mode_t'(item.requested_mode);
				end
			end
			default: ;
		endcase

		if (do_enter) begin
			if (enter_m == MODE_OFF) begin
				vac_d  = 1'b0;
				mode_d = MODE_OFF;
			end else if ((item.valve_a_pin && want_a) || (item.valve_b_pin && !want_a)) begin
				vac_d    = 1'b0;
				valve_d  = 1'b1;
				target_d = enter_m;
				phase_d  = PH_SETTLE;
				settle_d = settle_load;
			end else begin
				vac_d  = 1'b1;
				mode_d = enter_m;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			target_q <= MODE_OFF;
			phase_q  <= PH_IDLE;
			settle_q <= '0;
			spin_q   <= '0;
			vac_q    <= 1'b0;
			valve_q  <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_d;
			target_q <= target_d;
			phase_q  <= phase_d;
			settle_q <= settle_d;
			spin_q   <= spin_d;
			vac_q    <= vac_d;
			valve_q  <= valve_d;
		end
	end

	assign res.vac_motor_on   = vac_d;
	assign res.valve_motor_on = valve_d;
	assign res.mode_now       = mode_d;
	assign res.busy_res       = (phase_d != PH_IDLE);
	assign res.ignored        = ign;

endmodule

### sv/dust_extractor_valve_controller_top.sv
// ---------------------------------------------------------------------------
// dust_extractor_valve_controller_top
// vacuum and valve motor controller for two tool outlets
// ---------------------------------------------------------------------------
// cmd_ch carries one item per handshake: a millisecond tick with the two
// current samples and valve sensor pins, a set-mode or a toggle request.
// status_ch returns exactly one status item per command item, in order,
// with the motor drives, the committed mode, busy and the ignored flag.
// cfg_we/cfg_index/cfg_data write the threshold and timing registers;
// write them only while no item is in flight.
// an accepted item is held in the input register until the status
// register is free; then the state update and its status are registered
// together, and the status item is offered on status_ch.
// one item per cycle is sustained while status_ch.ready stays high.
// the status register holds a valid status while status_ch.ready is low; the input
// register keeps taking items until it is full, then cmd_ch.ready drops.
// reset clears the mode to off with both motors stopped and no switching
// in progress; the registers return to threshold 52, settle 25, spin 100.
// ---------------------------------------------------------------------------
module dust_extractor_valve_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	devc_cmd_if.sink                       cmd_ch,
	devc_status_if.source                  status_ch,
	input  logic                           cfg_we,
	input  logic [devc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [devc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import devc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    step;

	assign out_free     = !valid_s2 || status_ch.ready;
	assign step         = valid_s1 && out_free;
	assign cmd_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd_ch.ready)
				valid_s1 <= cmd_ch.valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			item_s1.cmd            <= cmd_ch.cmd;
			item_s1.requested_mode <= cmd_ch.requested_mode;
			item_s1.amps_a         <= cmd_ch.amps_a;
			item_s1.amps_b         <= cmd_ch.amps_b;
			item_s1.valve_a_pin    <= cmd_ch.valve_a_pin;
			item_s1.valve_b_pin    <= cmd_ch.valve_b_pin;
		end
		if (step)
			res_s2 <= res;
	end

	devc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	devc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign status_ch.valid          = valid_s2;
	assign status_ch.vac_motor_on   = res_s2.vac_motor_on;
	assign status_ch.valve_motor_on = res_s2.valve_motor_on;
	assign status_ch.mode_now       = res_s2.mode_now;
	assign status_ch.busy_res       = res_s2.busy_res;
	assign status_ch.ignored        = res_s2.ignored;

endmodule

### sv/devc_checker.sv
// ---------------------------------------------------------------------------
// devc_checker
// port-level checks on the status channel of the valve controller
// ---------------------------------------------------------------------------
`include "dust_extractor_valve_controller_top_macros.svh"

module devc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic       vac_motor_on,
	input logic       valve_motor_on,
	input logic [2:0] mode_now,
	input logic       busy_res,
	input logic       ignored
);

	// a stalled status item holds its mode, busy flag and vacuum drive
	`DEVC_ASSERT_NEXT(a_hold, clk, arst_n, valid && !ready, valid && $stable(mode_now) && $stable(busy_res) && $stable(vac_motor_on), "status changed while stalled")

	// valve motor runs exactly while switching, vacuum off meanwhile
	`DEVC_ASSERT_ALWAYS(a_valve_busy, clk, arst_n, !valid || (valve_motor_on == busy_res && !(busy_res && vac_motor_on)), "motor drives disagree with busy")

	// a request is only dropped while switching
	`DEVC_ASSERT_ALWAYS(a_ign_busy, clk, arst_n, !valid || !ignored || busy_res, "ignored without busy")

endmodule

bind dust_extractor_valve_controller_top devc_checker u_devc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (status_ch.valid),
	.ready          (status_ch.ready),
	.vac_motor_on   (status_ch.vac_motor_on),
	.valve_motor_on (status_ch.valve_motor_on),
	.mode_now       (status_ch.mode_now),
	.busy_res       (status_ch.busy_res),
	.ignored        (status_ch.ignored)
);
